// File: hdl/cau_pkg.sv
// Package for the complex arithmetic unit: opcodes, sequencer states.
// No dependencies.
package cau_pkg;
   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_CONJ = 4'd4,
      OP_ACC_ADD = 4'd5, OP_ACC_SUB = 4'd6, OP_ACC_MUL = 4'd7, OP_ACC_DIV = 4'd8,
      OP_LOAD = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV, ST_DONE
   } state_type;
endpackage

// File: hdl/cau_if.sv
// Valid/ready channel carrying one request or response item.
// Depends on nothing; payload width set by DATA_WIDTH.
interface cau_req_if #(parameter int DATA_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic [3:0]                    req_type;
   logic signed [DATA_WIDTH-1:0]  a_real;
   logic signed [DATA_WIDTH-1:0]  a_imag;
   logic signed [DATA_WIDTH-1:0]  b_real;
   logic signed [DATA_WIDTH-1:0]  b_imag;
   modport source (output valid, req_type, a_real, a_imag, b_real, b_imag, input ready);
   modport sink   (input valid, req_type, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [DATA_WIDTH-1:0]  res_real;
   logic signed [DATA_WIDTH-1:0]  res_imag;
   logic                          div_zero;
   logic                          overflow;
   modport source (output valid, res_real, res_imag, div_zero, overflow, input ready);
   modport sink   (input valid, res_real, res_imag, div_zero, overflow, output ready);
endinterface

// File: hdl/complex_arithmetic_unit.sv
// Complex ALU with accumulator, signed fixed point (Q15.16 by default).
// Path from input accept to rsp.valid: add/sub/conj/load, unknown opcodes and zero divisor
// go ST_IDLE -> ST_DONE, mul ST_IDLE -> ST_MUL -> ST_DONE, div adds ST_DIV after ST_MUL,
// one restoring-divider quotient bit per cycle, shared by both result parts.
// One item at a time; the next item is taken in the cycle after the result leaves.
// Reset (synchronous, active high) clears the accumulator, the state register and the output valid.
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic clock,
   input logic reset,
   cau_req_if.sink   req,
   cau_rsp_if.source rsp
);
   import cau_pkg::*;

   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2 * DW + 2;        // product sum width, exact
   localparam int QN  = PW + FRAC_BITS;    // dividend bits
   localparam int CW  = $clog2(QN + 1);

   state_type state_ff, state_in;

   logic [3:0]           op_ff;
   logic signed [DW-1:0] xr_ff, xi_ff, yr_ff, yi_ff;
   logic signed [DW-1:0] acc_r_ff, acc_i_ff;
   logic signed [DW-1:0] rr_ff, ri_ff;
   logic                 dz_ff, ovf_ff, rvalid_ff;

   // shared multiplier: one DW x DW product per cycle
   logic [1:0]           mstep_ff;
   logic signed [DW-1:0] mx, my;
   logic signed [2*DW-1:0] prod_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff;   // accumulated sums

   // divider
   logic                 part_ff;           // 0 real, 1 imag
   logic [CW-1:0]        cnt_ff;
   logic [PW-1:0]        num_ff;            // magnitude of numerator
   logic                 neg_ff;
   logic [PW:0]          rem_ff;
   logic [DW+1:0]        quo_ff;
   logic                 big_ff;

   wire start = req.valid && req.ready;
   wire [3:0] rt = req.req_type;
   wire is_acc = (rt == OP_ACC_ADD) || (rt == OP_ACC_SUB) ||
                 (rt == OP_ACC_MUL) || (rt == OP_ACC_DIV);
   wire [3:0] base_op = is_acc ? rt - 4'd5 : rt;

   // saturate a PW-bit signed value to DW bits
   function automatic logic [DW:0] sat_f(input logic signed [PW-1:0] v);
      logic signed [DW-1:0] mx_v, mn_v;
      mx_v = {1'b0, {(DW-1){1'b1}}};
      mn_v = {1'b1, {(DW-1){1'b0}}};
      if (v > PW'(mx_v)) sat_f = {1'b1, mx_v};
      else if (v < PW'(mn_v)) sat_f = {1'b1, mn_v};
      else sat_f = {1'b0, v[DW-1:0]};
   endfunction

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;

   // immediate ops: result straight from the request (or the accumulator)
   wire signed [DW-1:0] opx_r = is_acc ? acc_r_ff : req.a_real;
   wire signed [DW-1:0] opx_i = is_acc ? acc_i_ff : req.a_imag;
   logic [DW:0]          s0, s1;
   logic signed [DW-1:0] imm_rr, imm_ri;
   logic                 imm_dz, imm_ovf;
   always_comb begin
      s0      = '0;
      s1      = '0;
      imm_rr  = acc_r_ff;
      imm_ri  = acc_i_ff;
      imm_dz  = 1'b0;
      imm_ovf = 1'b0;
      case (base_op)
         OP_ADD: begin
            s0 = sat_f(PW'(opx_r) + PW'(req.b_real));
            s1 = sat_f(PW'(opx_i) + PW'(req.b_imag));
            imm_rr = s0[DW-1:0]; imm_ri = s1[DW-1:0];
            imm_ovf = s0[DW] | s1[DW];
         end
         OP_SUB: begin
            s0 = sat_f(PW'(opx_r) - PW'(req.b_real));
            s1 = sat_f(PW'(opx_i) - PW'(req.b_imag));
            imm_rr = s0[DW-1:0]; imm_ri = s1[DW-1:0];
            imm_ovf = s0[DW] | s1[DW];
         end
         OP_CONJ: if (!is_acc) begin
            s1 = sat_f(-PW'(req.a_imag));
            imm_rr = req.a_real; imm_ri = s1[DW-1:0];
            imm_ovf = s1[DW];
         end
         OP_DIV: if (req.b_real == '0 && req.b_imag == '0) begin
            imm_rr = '0; imm_ri = '0; imm_dz = 1'b1;
         end
         default: begin
            if (rt == OP_LOAD) begin
               imm_rr = req.a_real; imm_ri = req.a_imag;
            end
         end
      endcase
   end

   // multiply step schedule
   // mul real: xr*yr - xi*yi ; mul imag: xr*yi + xi*yr ; div den: yr^2 + yi^2
   // steps 0..3 feed the pa/pb products; for division steps 4..5 feed pc
   logic [2:0] mcnt_ff;
   always_comb begin
      case (mcnt_ff)
         3'd0: begin mx = xr_ff; my = yr_ff; end
         3'd1: begin mx = xi_ff; my = yi_ff; end
         3'd2: begin mx = xr_ff; my = yi_ff; end
         3'd3: begin mx = xi_ff; my = yr_ff; end
         3'd4: begin mx = yr_ff; my = yr_ff; end
         default: begin mx = yi_ff; my = yi_ff; end
      endcase
   end

   wire is_div  = (op_ff == OP_DIV);
   wire [2:0] mlast = is_div ? 3'd6 : 3'd4;   // number of product steps; step mlast drains the last product
   wire mul_done = (state_ff == ST_MUL) && (mcnt_ff == mlast);

   // product result, scaled back and saturated
   logic [DW:0] m0, m1;
   assign m0 = sat_f(pa_ff >>> FRAC_BITS);
   assign m1 = sat_f((pb_ff + PW'(prod_ff)) >>> FRAC_BITS);

   // divider datapath
   wire [PW-1:0] den = pc_ff[PW-1:0];
   wire dbit = (cnt_ff >= CW'(FRAC_BITS)) ? num_ff[cnt_ff - CW'(FRAC_BITS)] : 1'b0;
   wire [PW+1:0] sh  = {rem_ff, dbit};
   wire ge = sh >= {2'b0, den};
   wire [PW:0] rem_next = ge ? (PW+1)'(sh - {2'b0, den}) : sh[PW:0];
   wire div_last = (state_ff == ST_DIV) && (cnt_ff == '0);
   logic [DW+1:0] half_sign, sign_b;
   assign sign_b    = (DW+2)'(1) << (DW-1);
   assign half_sign = (DW+2)'(1) << (DW-2);

   // quotient with saturation at end of part
   logic [DW+1:0] quo_fin;
   logic          big_fin;
   always_comb begin
      big_fin = big_ff;
      quo_fin = quo_ff;
      if (!big_ff) begin
         if (quo_ff > half_sign) big_fin = 1'b1;
         else begin
            quo_fin = {quo_ff[DW:0], ge};
            if (quo_fin > sign_b) big_fin = 1'b1;
         end
      end
   end
   wire big_part = big_fin || (quo_fin > (neg_ff ? sign_b : sign_b - 1'b1));
   wire [DW-1:0] dq = big_part ? (neg_ff ? sign_b[DW-1:0] : sign_b[DW-1:0] - 1'b1)
                               : (neg_ff ? DW'(0 - quo_fin) : quo_fin[DW-1:0]);

   // start numerator for a divide part; sum is exact in PW bits
   function automatic logic [PW:0] mag_f(input logic signed [PW-1:0] v);
      mag_f = {v[PW-1], v[PW-1] ? PW'(-v) : PW'(v)};
   endfunction

   logic [PW:0] mr, mi;
   assign mr = mag_f(pa_ff);
   assign mi = mag_f(pb_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) begin
            if (base_op == OP_MUL || base_op == OP_DIV) begin
               if (base_op == OP_DIV && req.b_real == '0 && req.b_imag == '0)
                  state_in = ST_DONE;
               else
                  state_in = ST_MUL;
            end else state_in = ST_DONE;
         end
         ST_MUL:  if (mul_done) state_in = is_div ? ST_DIV : ST_DONE;
         ST_DIV:  if (div_last && part_ff) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath and results
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_r_ff  <= '0;
         acc_i_ff  <= '0;
         rvalid_ff <= 1'b0;
         mcnt_ff   <= '0;
         mstep_ff  <= '0;
      end else begin
         if (rsp.valid && rsp.ready) rvalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (start) begin
               op_ff  <= base_op;
               xr_ff  <= opx_r;
               xi_ff  <= opx_i;
               yr_ff  <= req.b_real;
               yi_ff  <= req.b_imag;
               dz_ff  <= imm_dz;
               ovf_ff <= imm_ovf;
               mcnt_ff <= '0;
               pa_ff <= '0; pb_ff <= '0; pc_ff <= '0;
               // hold the acc flag and the load flag in mstep
               mstep_ff <= {is_acc, rt == OP_LOAD};
               rr_ff <= imm_rr;
               ri_ff <= imm_ri;
            end
            ST_MUL: begin
               // advance one product per cycle, accumulate the previous one
               prod_ff <= mx * my;
               mcnt_ff <= mcnt_ff + 3'd1;
               case (mcnt_ff)
                  3'd1: pa_ff <= PW'(prod_ff);
                  3'd2: pa_ff <= is_div ? pa_ff + PW'(prod_ff) : pa_ff - PW'(prod_ff);
                  3'd3: pb_ff <= PW'(prod_ff);
                  3'd4: pb_ff <= is_div ? pb_ff - PW'(prod_ff) : pb_ff + PW'(prod_ff);
                  3'd5: pc_ff <= PW'(prod_ff);
                  3'd6: pc_ff <= pc_ff + PW'(prod_ff);
                  default: ;
               endcase
               if (mul_done) begin
                  if (is_div) begin
                     // pb for div: xi*yr - xr*yi; pb holds xr*yi - xi*yr, flip
                     pb_ff   <= -pb_ff;
                     part_ff <= 1'b0;
                     cnt_ff  <= CW'(QN - 1);
                     rem_ff  <= '0;
                     quo_ff  <= '0;
                     big_ff  <= 1'b0;
                     num_ff  <= mr[PW-1:0];
                     neg_ff  <= mr[PW];
                  end else begin
                     rr_ff <= m0[DW-1:0]; ri_ff <= m1[DW-1:0];
                     ovf_ff <= m0[DW] | m1[DW];
                  end
               end
            end
            ST_DIV: begin
               if (div_last && !part_ff) begin
                  // real part done: store it and restart on the imaginary numerator
                  rr_ff   <= dq;
                  part_ff <= 1'b1;
                  cnt_ff  <= CW'(QN - 1);
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  big_ff  <= 1'b0;
                  num_ff  <= mi[PW-1:0];
                  neg_ff  <= mi[PW];
               end else begin
                  rem_ff <= rem_next;
                  quo_ff <= quo_fin;
                  big_ff <= big_fin;
                  cnt_ff <= cnt_ff - 1'b1;
                  if (div_last) ri_ff <= dq;
               end
               if (div_last) ovf_ff <= ovf_ff | big_part;
            end
            ST_DONE: begin
               rvalid_ff <= 1'b1;
               if (mstep_ff != 2'b00) begin
                  acc_r_ff <= rr_ff;
                  acc_i_ff <= ri_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid    = rvalid_ff;
   assign rsp.res_real = rr_ff;
   assign rsp.res_imag = ri_ff;
   assign rsp.div_zero = dz_ff;
   assign rsp.overflow = ovf_ff;
endmodule

// File: tb/cau_checker.sv
`timescale 1ns / 1ps
// Checker for the complex arithmetic unit: watches both channels, predicts each result.
// Depends on cau_pkg and the channel interfaces in cau_if.sv.
module cau_checker (
   input  logic clock,
   input  logic reset,
   cau_req_if   req,
   cau_rsp_if   rsp,
   output int   fail_count,
   output int   pending
);
   import cau_pkg::*;

   typedef struct packed {
      logic [31:0] re;
      logic [31:0] im;
      logic        dz;
      logic        ovf;
   } cplx_result_type;

   localparam logic signed [127:0] MAX_Q = 128'sd2147483647;
   localparam logic signed [127:0] MIN_Q = -128'sd2147483648;

   cplx_result_type result_q[$];
   logic [31:0]  acc_re, acc_im;

   function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
      if (v > MAX_Q) begin
         ovf = 1'b1;
         return 32'h7fffffff;
      end
      if (v < MIN_Q) begin
         ovf = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // Quotient of a signed numerator by a positive divisor, scaled by 2^16, toward zero.
   function automatic logic [31:0] div_part(input logic signed [127:0] num,
                                            input logic [127:0] den, inout logic ovf);
      logic        neg;
      logic [127:0] mag, quo;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = (mag << 16) / den;
      if (quo > (neg ? 128'h80000000 : 128'h7fffffff)) begin
         ovf = 1'b1;
         return neg ? 32'h80000000 : 32'h7fffffff;
      end
      return neg ? 32'(-quo) : quo[31:0];
   endfunction

   function automatic cplx_result_type compute(input op_type op, input logic signed [31:0] xr,
         input logic signed [31:0] xi, input logic signed [31:0] yr,
         input logic signed [31:0] yi);
      cplx_result_type r;
      logic signed [127:0] a, b, c, d, den;
      a = xr; b = xi; c = yr; d = yi;
      r = '0;
      case (op)
         OP_ADD: begin
            r.re = clamp(a + c, r.ovf);
            r.im = clamp(b + d, r.ovf);
         end
         OP_SUB: begin
            r.re = clamp(a - c, r.ovf);
            r.im = clamp(b - d, r.ovf);
         end
         OP_MUL: begin
            r.re = clamp((a * c - b * d) >>> 16, r.ovf);
            r.im = clamp((a * d + b * c) >>> 16, r.ovf);
         end
         OP_DIV: begin
            if (yr == 0 && yi == 0) begin
               r.dz = 1'b1;
            end else begin
               den  = c * c + d * d;
               r.re = div_part(a * c + b * d, den, r.ovf);
               r.im = div_part(b * c - a * d, den, r.ovf);
            end
         end
         default: begin
            r.re = xr;
            r.im = clamp(-b, r.ovf);
         end
      endcase
      return r;
   endfunction

   function automatic cplx_result_type predict(input logic [3:0] t, input logic [31:0] ar,
         input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
      cplx_result_type r;
      r = '{acc_re, acc_im, 1'b0, 1'b0};
      if (t <= OP_CONJ) begin
         r = compute(op_type'(t), ar, ai, br, bi);
      end else if (t <= OP_ACC_DIV) begin
         r = compute(op_type'(t - OP_ACC_ADD), acc_re, acc_im, br, bi);
         acc_re = r.re;
         acc_im = r.im;
      end else if (t == OP_LOAD) begin
         r = '{ar, ai, 1'b0, 1'b0};
         acc_re = ar;
         acc_im = ai;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cplx_result_type want, got;
      if (reset) begin
         acc_re = '0;
         acc_im = '0;
         result_q.delete();
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (req.valid && req.ready)
            result_q.push_back(predict(req.req_type, req.a_real, req.a_imag,
                                       req.b_real, req.b_imag));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.res_real, rsp.res_imag, rsp.div_zero, rsp.overflow};
            if (result_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with nothing expected: %h %h dz=%b ovf=%b",
                           $realtime, got.re, got.im, got.dz, got.ovf);
               fail_count <= fail_count + 1;
            end else begin
               want = result_q.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp %h %h dz=%b ovf=%b got %h %h dz=%b ovf=%b",
                              $realtime, want.re, want.im, want.dz, want.ovf,
                              got.re, got.im, got.dz, got.ovf);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= result_q.size();
      end
   end
endmodule

// File: tb/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// Top of the complex arithmetic unit testbench: clock, reset, stimulus and verdict.
// Depends on cau_pkg, cau_if.sv, complex_arithmetic_unit and cau_checker.
module tb_complex_arithmetic_unit;
   import cau_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_cycles;
   int   quiet_cycles;
   int   fail_count;
   int   pending;

   cau_req_if #(.DATA_WIDTH(32)) req_ch ();
   cau_rsp_if #(.DATA_WIDTH(32)) rsp_ch ();

   complex_arithmetic_unit #(.DATA_WIDTH(32), .FRAC_BITS(16)) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   cau_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: stall at random, or hold off entirely while hold_cycles runs down.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: count cycles with no item moving on either channel.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_complex_arithmetic_unit: errors");
            $finish;
         end
      end
   end

   // Drive one item at the falling edge and hold it until accepted.
   task automatic send_item(input logic [3:0] t, input logic [31:0] ar, input logic [31:0] ai,
                            input logic [31:0] br, input logic [31:0] bi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.req_type = t;
      req_ch.a_real   = ar;
      req_ch.a_imag   = ai;
      req_ch.b_real   = br;
      req_ch.b_imag   = bi;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Operand mix: extremes, zero, small fixed-point values, and full-range noise.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h80000000;
         1:       return 32'h7fffffff;
         2:       return 32'h0;
         3, 4, 5: return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_items(input int count);
      logic [3:0]  t;
      logic [31:0] br, bi;
      repeat (count) begin
         // mostly real opcodes, occasionally an unknown one
         t  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(OP_ADD, OP_LOAD));
         br = pick_operand();
         bi = pick_operand();
         if ($urandom_range(0, 15) == 0) begin
            br = '0;
            bi = '0;
         end
         send_item(t, pick_operand(), pick_operand(), br, bi);
      end
   endtask

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.req_type = OP_ADD;
      req_ch.a_real   = '0;
      req_ch.a_imag   = '0;
      req_ch.b_real   = '0;
      req_ch.b_imag   = '0;
      hold_cycles     = 0;
      send_idle_pct   = 9;
      recv_idle_pct   = 46;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes of every op, zero divisor, conj of most negative, unknown types.
      send_item(OP_ADD,  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_item(OP_SUB,  32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_item(OP_MUL,  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_item(OP_MUL,  32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      send_item(OP_MUL,  32'hffff8000, 32'h00018000, 32'h00020000, 32'hfffe0000);
      send_item(OP_DIV,  32'h00030000, 32'h00040000, 32'h00010000, 32'hffff0000);
      send_item(OP_DIV,  32'h00030000, 32'h00040000, 32'h0, 32'h0);
      send_item(OP_DIV,  32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
      send_item(OP_DIV,  32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_item(OP_CONJ, 32'h12345678, 32'h80000000, 32'hffffffff, 32'hffffffff);
      send_item(OP_CONJ, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
      send_item(OP_LOAD, 32'h00010000, 32'hffff0000, 32'h55555555, 32'haaaaaaaa);
      send_item(OP_ACC_ADD, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h00020000);
      send_item(OP_ACC_SUB, 32'h0, 32'h0, 32'h80000000, 32'h00010000);
      send_item(OP_ACC_MUL, 32'h0, 32'h0, 32'h00008000, 32'hffff8000);
      send_item(OP_ACC_DIV, 32'h0, 32'h0, 32'h00000100, 32'h00000001);
      send_item(OP_ACC_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(4'd10, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_item(OP_LOAD, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
      send_item(4'd15, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(4'd12, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(OP_ACC_ADD, 32'h0, 32'h0, 32'h80000000, 32'h80000000);

      // Random: three idling phases.
      random_items(230);
      send_idle_pct = 46;
      recv_idle_pct = 9;
      random_items(230);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // Hold off the receiver long enough that the block backs up its input.
      hold_cycles = 600;
      random_items(240);
      req_ch.valid = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("tb_complex_arithmetic_unit: clean");
      else
         $display("tb_complex_arithmetic_unit: errors");
      $finish;
   end
endmodule

// File: sim.f
hdl/cau_pkg.sv
hdl/cau_if.sv
hdl/complex_arithmetic_unit.sv
tb/cau_checker.sv
tb/tb_complex_arithmetic_unit.sv
